>>> hdl/pbfr_pkg.sv
`timescale 1ns / 1ps

package pbfr_pkg;

   // frame geometry
   localparam int MAX_FRAME  = 64;
   localparam int HEADER_LEN = 4;
   localparam int CNT_W      = $clog2(MAX_FRAME + 1);
   localparam int HDR_IDX_W  = $clog2(HEADER_LEN);

   // shortest frame that carries a full data header
   localparam int MIN_DATA_FRAME = 6;

   // lowest device address; anything below is a reserved code
   localparam logic [6:0] ADDR_FLOOR = 7'h08;

   // raw byte codes on the line
   localparam logic [7:0] BYTE_MARK = 8'hff;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ACK  = 8'h01;

   // queue between deframer and classifier
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIMARY_ADDR = 1'd1;

   localparam logic [6:0] OWN_ID_RESET       = 7'd11;
   localparam logic [6:0] PRIMARY_ADDR_RESET = 7'd8;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_MARK   = 2'd1,
      PHASE_MARKED = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BUS_RELEASED = 2'd0,
      BUS_ASSIGNED = 2'd1,
      BUS_WROTE    = 2'd2,
      BUS_READ     = 2'd3
   } bus_state_type;

   typedef enum logic [3:0] {
      VERDICT_ACK          = 4'd0,
      VERDICT_RELEASE      = 4'd1,
      VERDICT_ASSIGN       = 4'd2,
      VERDICT_UNKNOWN_MAC  = 4'd3,
      VERDICT_SHORT        = 4'd4,
      VERDICT_WRONG_SENDER = 4'd5,
      VERDICT_BAD_READ     = 4'd6,
      VERDICT_BAD_WRITE    = 4'd7,
      VERDICT_HDR_MISMATCH = 4'd8,
      VERDICT_AWAIT_ACK    = 4'd9,
      VERDICT_UNASSIGNED   = 4'd10,
      VERDICT_FORWARD      = 4'd11
   } verdict_type;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_EOF  = 1'b1
   } kind_type;

   // one event from the deframer: a stored byte or an end of frame
   // len is the stored count including this byte, or the frame length
   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [CNT_W-1:0] len;
   } event_type;

   typedef struct packed {
      logic [6:0] own_id;
      logic [6:0] primary_addr;
   } cfg_type;

endpackage

>>> hdl/pbfr_req_if.sv
`timescale 1ns / 1ps

interface pbfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hdl/pbfr_rsp_if.sv
`timescale 1ns / 1ps

interface pbfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] data_byte;
   logic [5:0] byte_index;
   logic [3:0] verdict;
   logic       protocol_warning;
   logic       poll_for_us;
   logic [1:0] bus_state_out;
   logic [6:0] polled_device;
   logic [6:0] frame_length;

   modport source (
      output valid, output result_kind, output data_byte, output byte_index,
      output verdict, output protocol_warning, output poll_for_us,
      output bus_state_out, output polled_device, output frame_length,
      input ready
   );
   modport sink (
      input valid, input result_kind, input data_byte, input byte_index,
      input verdict, input protocol_warning, input poll_for_us,
      input bus_state_out, input polled_device, input frame_length,
      output ready
   );
endinterface

>>> hdl/pbfr_csr_if.sv
`timescale 1ns / 1ps

interface pbfr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pbfr_pkg::CSR_IDX_W-1:0] reg_index;
   logic [6:0]                     wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hdl/pbfr_front.sv
`timescale 1ns / 1ps

module pbfr_front (
   input  logic                  clock,
   input  logic                  reset,
   pbfr_req_if.sink              req,
   input  logic                  q_full,
   output logic                  q_push,
   output pbfr_pkg::event_type   q_item
);

   pbfr_pkg::phase_type           phase_ff, phase_in;
   logic [pbfr_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          beat;
   logic                          store;

   assign req.ready = !q_full;
   assign beat      = req.valid && req.ready;

   // escape stripping and frame byte counting
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      store    = 1'b0;
      q_push   = 1'b0;
      q_item   = '{kind: pbfr_pkg::KIND_DATA, data: req.rx_byte, len: count_ff};
      if (beat) begin
         case (phase_ff)
            pbfr_pkg::PHASE_IDLE: begin
               if (req.rx_byte == pbfr_pkg::BYTE_MARK) begin
                  phase_in = pbfr_pkg::PHASE_MARK;
               end else begin
                  store = 1'b1;
               end
            end
            pbfr_pkg::PHASE_MARK: begin
               if (req.rx_byte == pbfr_pkg::BYTE_ZERO) begin
                  phase_in = pbfr_pkg::PHASE_MARKED;
               end else begin
                  // doubled mark is a literal, anything else is dropped
                  phase_in = pbfr_pkg::PHASE_IDLE;
                  store    = (req.rx_byte == pbfr_pkg::BYTE_MARK);
               end
            end
            pbfr_pkg::PHASE_MARKED: begin
               phase_in = pbfr_pkg::PHASE_IDLE;
               if (req.rx_byte == pbfr_pkg::BYTE_ZERO) begin
                  // end of frame
                  count_in    = '0;
                  q_push      = 1'b1;
                  q_item.kind = pbfr_pkg::KIND_EOF;
               end else begin
                  store = 1'b1;
               end
            end
            default: begin
               phase_in = pbfr_pkg::PHASE_IDLE;
               store    = 1'b1;
            end
         endcase
      end
      // bytes past the frame limit are dropped
      if (store && (count_ff < pbfr_pkg::CNT_W'(pbfr_pkg::MAX_FRAME))) begin
         count_in   = count_ff + 1'b1;
         q_push     = 1'b1;
         q_item.len = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pbfr_pkg::PHASE_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/pbfr_queue.sv
`timescale 1ns / 1ps

module pbfr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pbfr_pkg::event_type  push_item,
   output logic                 full,
   input  logic                 pop,
   output pbfr_pkg::event_type  pop_item,
   output logic                 empty
);

   pbfr_pkg::event_type             slot_ff [pbfr_pkg::QUEUE_DEPTH];
   logic [pbfr_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pbfr_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pbfr_pkg::QCNT_W-1:0]     fill_ff, fill_in;
   logic                            do_push;
   logic                            do_pop;

   assign full     = (fill_ff == pbfr_pkg::QCNT_W'(pbfr_pkg::QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pbfr_pkg::QPTR_W'(pbfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pbfr_pkg::QPTR_W'(pbfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hdl/pbfr_back.sv
`timescale 1ns / 1ps

module pbfr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pbfr_pkg::cfg_type    cfg,
   input  logic                 q_empty,
   input  pbfr_pkg::event_type  q_item,
   output logic                 q_pop,
   pbfr_rsp_if.source           rsp
);

   logic [7:0]                    header_ff   [pbfr_pkg::HEADER_LEN];
   logic [7:0]                    expected_ff [pbfr_pkg::HEADER_LEN];
   pbfr_pkg::bus_state_type       bus_ff, bus_in;
   logic [6:0]                    owner_ff, owner_in;

   logic                          valid_ff;
   pbfr_pkg::kind_type            kind_ff;
   logic [7:0]                    data_ff;
   logic [5:0]                    index_ff;
   pbfr_pkg::verdict_type         verdict_ff;
   logic                          warn_ff;
   logic                          poll_ff;
   logic [1:0]                    bus_out_ff;
   logic [6:0]                    device_ff;
   logic [6:0]                    length_ff;

   pbfr_pkg::verdict_type         verdict_in;
   logic                          warn_in;
   logic                          poll_in;
   logic                          expect_load;
   logic                          mismatch;
   logic                          is_eof;
   logic [pbfr_pkg::CNT_W-1:0]    idx;
   logic [7:0]                    b0;
   logic [7:0]                    b1;
   logic [6:0]                    dst;
   logic                          from_master;

   assign q_pop  = !q_empty && (!valid_ff || rsp.ready);
   assign is_eof = (q_item.kind == pbfr_pkg::KIND_EOF);
   assign idx    = q_item.len - 1'b1;
   assign b0     = header_ff[0];
   assign b1     = header_ff[1];
   assign dst    = b1[6:0];
   assign from_master = (b0 == {1'b0, cfg.primary_addr});

   // read response header check
   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < pbfr_pkg::HEADER_LEN; i++) begin
         if (expected_ff[i] != header_ff[i]) begin
            mismatch = 1'b1;
         end
      end
   end

   // end of frame classification against the bus ownership state
   always_comb begin
      verdict_in  = pbfr_pkg::VERDICT_FORWARD;
      warn_in     = 1'b0;
      poll_in     = 1'b0;
      bus_in      = bus_ff;
      owner_in    = owner_ff;
      expect_load = 1'b0;
      if (q_item.len == pbfr_pkg::CNT_W'(1)) begin
         // single byte bus control message
         if (b0 == pbfr_pkg::BYTE_ACK) begin
            verdict_in = pbfr_pkg::VERDICT_ACK;
            warn_in    = (bus_ff != pbfr_pkg::BUS_WROTE);
            if (owner_ff == cfg.own_id) begin
               poll_in = 1'b1;
            end else begin
               bus_in = pbfr_pkg::BUS_ASSIGNED;
            end
         end else if (!b0[7] && (b0[6:0] >= pbfr_pkg::ADDR_FLOOR)) begin
            verdict_in = pbfr_pkg::VERDICT_RELEASE;
            warn_in    = (bus_ff != pbfr_pkg::BUS_ASSIGNED);
            owner_in   = '0;
            bus_in     = pbfr_pkg::BUS_RELEASED;
         end else if (b0[7]) begin
            verdict_in = pbfr_pkg::VERDICT_ASSIGN;
            warn_in    = (bus_ff != pbfr_pkg::BUS_RELEASED) &&
                         (bus_ff != pbfr_pkg::BUS_ASSIGNED);
            owner_in   = b0[6:0];
            if (b0[6:0] == cfg.own_id) begin
               poll_in = 1'b1;
            end else begin
               bus_in = pbfr_pkg::BUS_ASSIGNED;
            end
         end else begin
            verdict_in = pbfr_pkg::VERDICT_UNKNOWN_MAC;
         end
      end else if (q_item.len < pbfr_pkg::CNT_W'(pbfr_pkg::MIN_DATA_FRAME)) begin
         verdict_in = pbfr_pkg::VERDICT_SHORT;
         if ((bus_ff == pbfr_pkg::BUS_WROTE) || (bus_ff == pbfr_pkg::BUS_READ)) begin
            bus_in = pbfr_pkg::BUS_ASSIGNED;
         end
      end else if (from_master && ((bus_ff != pbfr_pkg::BUS_READ) || mismatch)) begin
         // master frame releases the bus; the recorded owner is kept
         bus_in = pbfr_pkg::BUS_RELEASED;
      end else if (bus_ff == pbfr_pkg::BUS_ASSIGNED) begin
         if ((b0 != {1'b0, owner_ff}) && !from_master) begin
            verdict_in = pbfr_pkg::VERDICT_WRONG_SENDER;
         end else if (b1[7]) begin
            if (dst < pbfr_pkg::ADDR_FLOOR) begin
               verdict_in = pbfr_pkg::VERDICT_BAD_READ;
            end else begin
               expect_load = 1'b1;
               bus_in      = pbfr_pkg::BUS_READ;
            end
         end else if ((dst != '0) && (dst < pbfr_pkg::ADDR_FLOOR)) begin
            verdict_in = pbfr_pkg::VERDICT_BAD_WRITE;
         end else if (dst >= pbfr_pkg::ADDR_FLOOR) begin
            bus_in = pbfr_pkg::BUS_WROTE;
         end
      end else if (bus_ff == pbfr_pkg::BUS_READ) begin
         bus_in = pbfr_pkg::BUS_ASSIGNED;
         if (mismatch) begin
            verdict_in = pbfr_pkg::VERDICT_HDR_MISMATCH;
         end else if (owner_ff == cfg.own_id) begin
            poll_in = 1'b1;
         end
      end else if (bus_ff == pbfr_pkg::BUS_WROTE) begin
         verdict_in = pbfr_pkg::VERDICT_AWAIT_ACK;
      end else if (!from_master) begin
         verdict_in = pbfr_pkg::VERDICT_UNASSIGNED;
      end
   end

   // bus ownership state and expected read header
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff   <= pbfr_pkg::BUS_RELEASED;
         owner_ff <= '0;
         for (int i = 0; i < pbfr_pkg::HEADER_LEN; i++) begin
            expected_ff[i] <= '0;
         end
      end else if (q_pop && is_eof) begin
         bus_ff   <= bus_in;
         owner_ff <= owner_in;
         if (expect_load) begin
            expected_ff[0] <= {1'b0, dst};
            expected_ff[1] <= b0;
            expected_ff[2] <= header_ff[2];
            expected_ff[3] <= header_ff[3];
         end
      end
   end

   // header capture, first bytes of each frame
   always_ff @(posedge clock) begin
      if (q_pop && !is_eof && (idx < pbfr_pkg::CNT_W'(pbfr_pkg::HEADER_LEN))) begin
         header_ff[idx[pbfr_pkg::HDR_IDX_W-1:0]] <= q_item.data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff   <= q_item.kind;
         length_ff <= 7'(q_item.len);
         if (is_eof) begin
            data_ff    <= '0;
            index_ff   <= '0;
            verdict_ff <= verdict_in;
            warn_ff    <= warn_in;
            poll_ff    <= poll_in;
            bus_out_ff <= bus_in;
            device_ff  <= owner_in;
         end else begin
            data_ff    <= q_item.data;
            index_ff   <= 6'(idx);
            verdict_ff <= pbfr_pkg::VERDICT_ACK;
            warn_ff    <= 1'b0;
            poll_ff    <= 1'b0;
            bus_out_ff <= bus_ff;
            device_ff  <= owner_ff;
         end
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.result_kind      = kind_ff;
   assign rsp.data_byte        = data_ff;
   assign rsp.byte_index       = index_ff;
   assign rsp.verdict          = verdict_ff;
   assign rsp.protocol_warning = warn_ff;
   assign rsp.poll_for_us      = poll_ff;
   assign rsp.bus_state_out    = bus_out_ff;
   assign rsp.polled_device    = device_ff;
   assign rsp.frame_length     = length_ff;

endmodule

>>> hdl/polled_bus_frame_receiver_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// req_ch    in   valid/ready    rx_byte
// rsp_ch    out  valid/ready    result_kind .. frame_length (one result a beat)
// csr_ch    in   valid/ready    reg_index, wdata (0 own_id, 1 primary_addr)
//
// one raw byte a cycle while the queue is not full; the deframer writes the
// two-entry queue, whose head the classifier registers into its output register
// synchronous reset clears phase, counts, bus state, owner and read header
// req_ch stalls only when the queue is full; csr_ch is always ready

module polled_bus_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   pbfr_req_if.sink    req_ch,
   pbfr_rsp_if.source  rsp_ch,
   pbfr_csr_if.sink    csr_ch
);

   logic                  own_id_ff;
   logic [6:0]            own_id_reg_ff;
   logic [6:0]            primary_addr_ff;
   pbfr_pkg::cfg_type     cfg;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_empty;
   pbfr_pkg::event_type   q_in_item;
   pbfr_pkg::event_type   q_out_item;

   assign csr_ch.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_reg_ff   <= pbfr_pkg::OWN_ID_RESET;
         primary_addr_ff <= pbfr_pkg::PRIMARY_ADDR_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            pbfr_pkg::CSR_OWN_ID:       own_id_reg_ff   <= csr_ch.wdata;
            pbfr_pkg::CSR_PRIMARY_ADDR: primary_addr_ff <= csr_ch.wdata;
            default: begin
            end
         endcase
      end
   end

   // marks that own_id has been written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= 1'b0;
      end else if (csr_ch.valid && (csr_ch.reg_index == pbfr_pkg::CSR_OWN_ID)) begin
         own_id_ff <= 1'b1;
      end
   end

   assign cfg.own_id       = own_id_ff ? own_id_reg_ff : pbfr_pkg::OWN_ID_RESET;
   assign cfg.primary_addr = primary_addr_ff;

   pbfr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (q_in_item)
   );

   pbfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .empty     (q_empty)
   );

   pbfr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_item  (q_out_item),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

>>> dv/polled_bus_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

module polled_bus_frame_receiver_core_tb;

   localparam int ITEMS       = 1300;
   localparam int N_PHASES    = 7;
   localparam int SETTLE      = 10;
   localparam int HOLD_CYCLES = 150;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      pbfr_pkg::kind_type      kind;
      logic [7:0]              data;
      logic [5:0]              pos;
      pbfr_pkg::verdict_type   verdict;
      logic                    warn;
      logic                    poll;
      pbfr_pkg::bus_state_type bus;
      logic [6:0]              owner;
      logic [6:0]              len;
   } result_type;

   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      result_type want;
   } row_type;

   localparam result_type NO_RESULT =
      '{pbfr_pkg::KIND_DATA, 8'h00, 6'd0, pbfr_pkg::VERDICT_ACK, 1'b0, 1'b0,
        pbfr_pkg::BUS_RELEASED, 7'd0, 7'd0};

   // directed bytes; typed rows carry a result that is plain at a glance
   localparam int N_DIRECTED = 30;
   localparam row_type DIRECTED [N_DIRECTED] = '{
      // empty frame
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b1, '{pbfr_pkg::KIND_EOF, 8'h00, 6'd0,
                                    pbfr_pkg::VERDICT_SHORT, 1'b0, 1'b0,
                                    pbfr_pkg::BUS_RELEASED, 7'd0, 7'd0}},
      // lowest byte value, then a literal mark byte
      '{pbfr_pkg::BYTE_ZERO, 1'b1, '{pbfr_pkg::KIND_DATA, 8'h00, 6'd0,
                                    pbfr_pkg::VERDICT_ACK, 1'b0, 1'b0,
                                    pbfr_pkg::BUS_RELEASED, 7'd0, 7'd1}},
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_MARK, 1'b1, '{pbfr_pkg::KIND_DATA, 8'hff, 6'd1,
                                    pbfr_pkg::VERDICT_ACK, 1'b0, 1'b0,
                                    pbfr_pkg::BUS_RELEASED, 7'd0, 7'd2}},
      // stray byte after a mark is dropped
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{8'h55,               1'b0, NO_RESULT},
      // marked nonzero byte is stored as plain data
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      '{8'h37,               1'b0, NO_RESULT},
      // close the short frame
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      // assign bus to our own address
      '{8'h8b,               1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b1, '{pbfr_pkg::KIND_EOF, 8'h00, 6'd0,
                                    pbfr_pkg::VERDICT_ASSIGN, 1'b0, 1'b1,
                                    pbfr_pkg::BUS_RELEASED, 7'd11, 7'd1}},
      // ack while we hold the bus
      '{pbfr_pkg::BYTE_ACK,  1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      // release from the top address
      '{8'h7f,               1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      // reserved code below the address floor
      '{8'h05,               1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_MARK, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b0, NO_RESULT},
      '{pbfr_pkg::BYTE_ZERO, 1'b1, '{pbfr_pkg::KIND_EOF, 8'h00, 6'd0,
                                    pbfr_pkg::VERDICT_UNKNOWN_MAC, 1'b0, 1'b0,
                                    pbfr_pkg::BUS_RELEASED, 7'd0, 7'd1}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbfr_req_if req_if ();
   pbfr_rsp_if rsp_if ();
   pbfr_csr_if csr_if ();

   polled_bus_frame_receiver_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // receiver state mirror
   logic [6:0]                          my_own_id    = pbfr_pkg::OWN_ID_RESET;
   logic [6:0]                          bus_primary  = pbfr_pkg::PRIMARY_ADDR_RESET;
   pbfr_pkg::phase_type                 esc_phase    = pbfr_pkg::PHASE_IDLE;
   int unsigned                         stored_count = 0;
   logic [pbfr_pkg::HEADER_LEN-1:0][7:0] frame_hdr   = '0;
   pbfr_pkg::bus_state_type             bus_st       = pbfr_pkg::BUS_RELEASED;
   logic [6:0]                          bus_owner    = 7'd0;
   logic [pbfr_pkg::HEADER_LEN-1:0][7:0] read_hdr    = '0;

   result_type expected_results [$];
   logic [7:0] line_bytes [$];
   result_type want;
   int         error_count   = 0;
   int         bytes_sent    = 0;
   int         results_taken = 0;
   int         cycle_count   = 0;
   bit         send_calm     = 1'b0;
   bit         recv_calm     = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // deframe one raw byte and classify at end of frame
   task automatic predict_byte(input logic [7:0] c, output bit produced,
                               output result_type r);
      bit                    keep;
      pbfr_pkg::verdict_type v;
      logic                  warn;
      logic                  poll;
      logic [7:0]            b0;
      logic [7:0]            b1;
      logic [6:0]            dst;
      bit                    mism;
      produced = 1'b0;
      r = NO_RESULT;
      keep = 1'b1;
      case (esc_phase)
         pbfr_pkg::PHASE_IDLE: begin
            if (c == pbfr_pkg::BYTE_MARK) begin
               esc_phase = pbfr_pkg::PHASE_MARK;
               keep = 1'b0;
            end
         end
         pbfr_pkg::PHASE_MARK: begin
            esc_phase = (c == pbfr_pkg::BYTE_ZERO) ? pbfr_pkg::PHASE_MARKED :
                                                     pbfr_pkg::PHASE_IDLE;
            keep = (c == pbfr_pkg::BYTE_MARK);
         end
         pbfr_pkg::PHASE_MARKED: begin
            if (c == pbfr_pkg::BYTE_ZERO) begin
               keep = 1'b0;
               v = pbfr_pkg::VERDICT_FORWARD;
               warn = 1'b0;
               poll = 1'b0;
               b0 = frame_hdr[0];
               b1 = frame_hdr[1];
               dst = b1[6:0];
               mism = (read_hdr != frame_hdr);
               if (stored_count == 1) begin
                  // bus mac messages
                  if (b0 == pbfr_pkg::BYTE_ACK) begin
                     v = pbfr_pkg::VERDICT_ACK;
                     warn = (bus_st != pbfr_pkg::BUS_WROTE);
                     if (bus_owner == my_own_id) poll = 1'b1;
                     else bus_st = pbfr_pkg::BUS_ASSIGNED;
                  end else if (b0 >= pbfr_pkg::ADDR_FLOOR && !b0[7]) begin
                     v = pbfr_pkg::VERDICT_RELEASE;
                     warn = (bus_st != pbfr_pkg::BUS_ASSIGNED);
                     bus_owner = 7'd0;
                     bus_st = pbfr_pkg::BUS_RELEASED;
                  end else if (b0[7]) begin
                     v = pbfr_pkg::VERDICT_ASSIGN;
                     warn = (bus_st != pbfr_pkg::BUS_RELEASED &&
                             bus_st != pbfr_pkg::BUS_ASSIGNED);
                     bus_owner = b0[6:0];
                     if (bus_owner == my_own_id) poll = 1'b1;
                     else bus_st = pbfr_pkg::BUS_ASSIGNED;
                  end else begin
                     v = pbfr_pkg::VERDICT_UNKNOWN_MAC;
                  end
               end else if (stored_count < pbfr_pkg::MIN_DATA_FRAME) begin
                  v = pbfr_pkg::VERDICT_SHORT;
                  if (bus_st == pbfr_pkg::BUS_WROTE || bus_st == pbfr_pkg::BUS_READ)
                     bus_st = pbfr_pkg::BUS_ASSIGNED;
               end else if (b0 == {1'b0, bus_primary} &&
                            (bus_st != pbfr_pkg::BUS_READ || mism)) begin
                  bus_st = pbfr_pkg::BUS_RELEASED;
               end else if (bus_st == pbfr_pkg::BUS_ASSIGNED) begin
                  // request from the current owner or the master
                  if (b0 != {1'b0, bus_owner} && b0 != {1'b0, bus_primary}) begin
                     v = pbfr_pkg::VERDICT_WRONG_SENDER;
                  end else if (b1[7]) begin
                     if (dst < pbfr_pkg::ADDR_FLOOR) begin
                        v = pbfr_pkg::VERDICT_BAD_READ;
                     end else begin
                        read_hdr[0] = {1'b0, dst};
                        read_hdr[1] = b0;
                        read_hdr[2] = frame_hdr[2];
                        read_hdr[3] = frame_hdr[3];
                        bus_st = pbfr_pkg::BUS_READ;
                     end
                  end else if (dst != 7'd0 && dst < pbfr_pkg::ADDR_FLOOR) begin
                     v = pbfr_pkg::VERDICT_BAD_WRITE;
                  end else if (dst >= pbfr_pkg::ADDR_FLOOR) begin
                     bus_st = pbfr_pkg::BUS_WROTE;
                  end
               end else if (bus_st == pbfr_pkg::BUS_READ) begin
                  bus_st = pbfr_pkg::BUS_ASSIGNED;
                  if (mism) v = pbfr_pkg::VERDICT_HDR_MISMATCH;
                  else if (bus_owner == my_own_id) poll = 1'b1;
               end else if (bus_st == pbfr_pkg::BUS_WROTE) begin
                  v = pbfr_pkg::VERDICT_AWAIT_ACK;
               end else if (b0 != {1'b0, bus_primary}) begin
                  v = pbfr_pkg::VERDICT_UNASSIGNED;
               end
               r = '{pbfr_pkg::KIND_EOF, 8'h00, 6'd0, v, warn, poll, bus_st, bus_owner,
                     7'(stored_count)};
               produced = 1'b1;
               esc_phase = pbfr_pkg::PHASE_IDLE;
               stored_count = 0;
            end else begin
               esc_phase = pbfr_pkg::PHASE_IDLE;
            end
         end
         default: esc_phase = pbfr_pkg::PHASE_IDLE;
      endcase
      // store the byte unless the frame is full
      if (keep && stored_count < pbfr_pkg::MAX_FRAME) begin
         if (stored_count < pbfr_pkg::HEADER_LEN) frame_hdr[stored_count] = c;
         stored_count++;
         r = '{pbfr_pkg::KIND_DATA, c, 6'(stored_count - 1), pbfr_pkg::VERDICT_ACK,
               1'b0, 1'b0, bus_st, bus_owner, 7'(stored_count)};
         produced = 1'b1;
      end
   endtask

   function automatic int draw_wait(input bit calm);
      if (calm || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic logic [7:0] rand_octet();
      if ($urandom_range(0, 15) == 0) return pbfr_pkg::BYTE_MARK;
      return 8'($urandom);
   endfunction

   // escape one frame byte onto the line, now and then with line noise
   function automatic void push_escaped(input logic [7:0] b);
      if ($urandom_range(0, 49) == 0) begin
         line_bytes.push_back(pbfr_pkg::BYTE_MARK);
         line_bytes.push_back(8'($urandom_range(1, 254)));
      end
      if (b == pbfr_pkg::BYTE_MARK) begin
         line_bytes.push_back(pbfr_pkg::BYTE_MARK);
         line_bytes.push_back(pbfr_pkg::BYTE_MARK);
      end else if (b != pbfr_pkg::BYTE_ZERO && $urandom_range(0, 39) == 0) begin
         line_bytes.push_back(pbfr_pkg::BYTE_MARK);
         line_bytes.push_back(pbfr_pkg::BYTE_ZERO);
         line_bytes.push_back(b);
      end else begin
         line_bytes.push_back(b);
      end
   endfunction

   // one random frame on the line, biased to what the bus state accepts
   function automatic void build_frame();
      int         sel;
      int         len;
      logic [7:0] pay [$];
      logic [6:0] id;
      logic [6:0] dst;
      sel = $urandom_range(0, 99);
      line_bytes.delete();
      if (sel < 28) begin
         case ($urandom_range(0, 3))
            0: pay.push_back(pbfr_pkg::BYTE_ACK);
            1: pay.push_back(8'($urandom_range(8, 127)));
            2: begin
               case ($urandom_range(0, 2))
                  0: id = my_own_id;
                  1: id = bus_primary;
                  default: id = 7'($urandom);
               endcase
               pay.push_back({1'b1, id});
            end
            default: pay.push_back(8'($urandom_range(0, 7)));
         endcase
      end else if (sel < 38) begin
         len = $urandom_range(0, pbfr_pkg::MIN_DATA_FRAME - 1);
         repeat (len) pay.push_back(rand_octet());
      end else if (sel < 44) begin
         // raw noise, no frame structure
         repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom));
         return;
      end else if (sel < 47) begin
         len = $urandom_range(pbfr_pkg::MAX_FRAME - 4, pbfr_pkg::MAX_FRAME + 6);
         repeat (len) pay.push_back(rand_octet());
      end else begin
         len = $urandom_range(pbfr_pkg::MIN_DATA_FRAME, 12);
         if (bus_st == pbfr_pkg::BUS_READ && $urandom_range(0, 1) == 0) begin
            for (int i = 0; i < pbfr_pkg::HEADER_LEN; i++) pay.push_back(read_hdr[i]);
         end else begin
            case ($urandom_range(0, 3))
               0, 1: pay.push_back({1'b0, bus_owner});
               2: pay.push_back({1'b0, bus_primary});
               default: pay.push_back(8'($urandom));
            endcase
            case ($urandom_range(0, 2))
               0: dst = 7'($urandom_range(8, 127));
               1: dst = 7'($urandom_range(0, 7));
               default: dst = my_own_id;
            endcase
            pay.push_back({1'($urandom_range(0, 1)), dst});
            pay.push_back(8'($urandom));
            pay.push_back(8'($urandom));
         end
         repeat (len - pbfr_pkg::HEADER_LEN) pay.push_back(rand_octet());
      end
      foreach (pay[i]) push_escaped(pay[i]);
      line_bytes.push_back(pbfr_pkg::BYTE_MARK);
      line_bytes.push_back(pbfr_pkg::BYTE_ZERO);
      line_bytes.push_back(pbfr_pkg::BYTE_ZERO);
   endfunction

   // offer one byte; keep valid high across back-to-back beats
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input result_type typed_want);
      int         gap;
      bit         produced;
      result_type r;
      gap = draw_wait(send_calm);
      if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
      predict_byte(b, produced, r);
      if (typed) expected_results.push_back(typed_want);
      else if (produced) expected_results.push_back(r);
   endtask

   // both registers in back-to-back beats
   task automatic write_config(input logic [6:0] own, input logic [6:0] mst);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= pbfr_pkg::CSR_OWN_ID;
      csr_if.wdata     <= own;
      do @(posedge clock); while (!csr_if.ready);
      my_own_id = own;
      csr_if.reg_index <= pbfr_pkg::CSR_PRIMARY_ADDR;
      csr_if.wdata     <= mst;
      do @(posedge clock); while (!csr_if.ready);
      bus_primary = mst;
      csr_if.valid <= 1'b0;
   endtask

   // wait for all results, then for the pipeline to empty
   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no expectation waiting");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("result_kind", want.kind, rsp_if.result_kind);
            check_field("data_byte", want.data, rsp_if.data_byte);
            check_field("byte_index", want.pos, rsp_if.byte_index);
            check_field("verdict", want.verdict, rsp_if.verdict);
            check_field("protocol_warning", want.warn, rsp_if.protocol_warning);
            check_field("poll_for_us", want.poll, rsp_if.poll_for_us);
            check_field("bus_state_out", want.bus, rsp_if.bus_state_out);
            check_field("polled_device", want.owner, rsp_if.polled_device);
            check_field("frame_length", want.len, rsp_if.frame_length);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side, with two long hold-offs to back up the input
   initial begin
      int pause;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pause = draw_wait(recv_calm);
         if (results_taken == 250 || results_taken == 800) pause = HOLD_CYCLES;
         if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
         if (pause > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         results_taken++;
      end
   end

   // stimulus
   initial begin
      req_if.valid     = 1'b0;
      req_if.rx_byte   = 8'h00;
      csr_if.valid     = 1'b0;
      csr_if.reg_index = pbfr_pkg::CSR_OWN_ID;
      csr_if.wdata     = 7'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph > 0) begin
            drain();
            case (ph)
               1: write_config(7'd8, 7'd0);
               2: write_config(7'd127, 7'd127);
               3: write_config(7'd20, 7'd20);
               4, 5: write_config(7'($urandom_range(8, 127)), 7'($urandom));
               default: write_config(pbfr_pkg::OWN_ID_RESET, pbfr_pkg::PRIMARY_ADDR_RESET);
            endcase
         end
         while (bytes_sent < (ph + 1) * ITEMS / N_PHASES) begin
            build_frame();
            foreach (line_bytes[i]) send_byte(line_bytes[i], 1'b0, NO_RESULT);
         end
      end
      drain();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/pbfr_pkg.sv
hdl/pbfr_req_if.sv
hdl/pbfr_rsp_if.sv
hdl/pbfr_csr_if.sv
hdl/pbfr_front.sv
hdl/pbfr_queue.sv
hdl/pbfr_back.sv
hdl/polled_bus_frame_receiver_core.sv
dv/polled_bus_frame_receiver_core_tb.sv
